[rtl/core/ring_buffer_delimiter_framer_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the framer checker
// ---------------------------------------------------------------------------
`ifndef RING_BUFFER_DELIMITER_FRAMER_CORE_MACROS_SVH
`define RING_BUFFER_DELIMITER_FRAMER_CORE_MACROS_SVH

// Clocked property, switched off while reset is high.
`define RBDF_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define RBDF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rbdf_pkg.sv]
// ---------------------------------------------------------------------------
// rbdf_pkg
// Types and constants of the delimiter framing ring buffer.
// ---------------------------------------------------------------------------
package rbdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned START_W = 6;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ_MSG = 2'd1,
    OP_READ_ALL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_WRITTEN = 3'd1,
    ST_FULL    = 3'd2,
    ST_NO_MSG  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_DELIM_LEN    = 2'd0,
    CFG_DELIM_FIRST  = 2'd1,
    CFG_DELIM_SECOND = 2'd2,
    CFG_START_POS    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EMIT,
    FSM_RESP
  } fsm_t;

  localparam logic [1:0]         RST_DELIM_LEN    = 2'd2;
  localparam logic [BYTE_W-1:0]  RST_DELIM_FIRST  = 8'd13;
  localparam logic [BYTE_W-1:0]  RST_DELIM_SECOND = 8'd10;

  typedef struct packed {
    op_t               operation;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [LEN_W-1:0]  msg_length;
    status_t           status;
  } out_item_t;

  // Delimiter settings seen by the sequencer
  typedef struct packed {
    logic [1:0]        delimiter_length;
    logic [BYTE_W-1:0] delimiter_first;
    logic [BYTE_W-1:0] delimiter_second;
  } delim_cfg_t;

  // Pointer restart request from a start position write
  typedef struct packed {
    logic               restart;
    logic [START_W-1:0] start_position;
  } restart_t;

endpackage

[rtl/core/rbdf_mem.sv]
// ---------------------------------------------------------------------------
// rbdf_mem
// Byte store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rbdf_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [PW-1:0]              waddr,
  input  logic [rbdf_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [PW-1:0]              raddr,
  output logic [rbdf_pkg::BYTE_W-1:0] rdata
);

  logic [rbdf_pkg::BYTE_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

[rtl/core/rbdf_ctrl.sv]
// ---------------------------------------------------------------------------
// rbdf_ctrl
// Sequencer: pointers, fill count, delimiter scan, byte emission and the
// output register.
// ---------------------------------------------------------------------------
module rbdf_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW    = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  rbdf_pkg::in_item_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output rbdf_pkg::out_item_t         rsp,
  input  rbdf_pkg::delim_cfg_t        cfg,
  input  rbdf_pkg::restart_t          rs,
  output logic                        mem_we,
  output logic [PW-1:0]               mem_waddr,
  output logic [rbdf_pkg::BYTE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [PW-1:0]               mem_raddr,
  input  logic [rbdf_pkg::BYTE_W-1:0] mem_rdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // pointer plus offset, offset never above DEPTH
  function automatic logic [PW-1:0] add_wrap(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  // start position folded into the store, as a table
  function automatic logic [PW-1:0] wrap_start(input logic [rbdf_pkg::START_W-1:0] p);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << rbdf_pkg::START_W); i++) begin
      if (p == rbdf_pkg::START_W'(i)) begin
        r = PW'(i % DEPTH);
      end
    end
    return r;
  endfunction

  rbdf_pkg::fsm_t state, state_next;

  logic [PW-1:0]               rp, rp_next;
  logic [PW-1:0]               wp, wp_next;
  logic [CW-1:0]               fill, fill_next;
  logic [PW-1:0]               base, base_next;
  logic [CW-1:0]               idx, idx_next;
  logic                        eval_valid, eval_valid_next;
  logic [CW-1:0]               eval_idx, eval_idx_next;
  logic [rbdf_pkg::BYTE_W-1:0] prev_byte, prev_byte_next;
  logic                        pend, pend_next;
  logic [CW-1:0]               ld, ld_next;
  logic [CW-1:0]               msg_len, msg_len_next;
  rbdf_pkg::status_t           resp_status, resp_status_next;
  logic                        out_valid, out_valid_next;
  rbdf_pkg::out_item_t         out_item, out_item_next;

  logic          out_free;
  logic          accept;
  logic          two;
  logic [CW-1:0] dlen;
  logic          m1, m2, found, scan_miss;
  logic [CW-1:0] at;
  logic          emit_load, emit_last, emit_issue, scan_issue;

  assign out_free   = !out_valid || !rsp_stall;
  assign req_stall  = !((state == rbdf_pkg::FSM_IDLE) && out_free);
  assign accept     = req_valid && !req_stall;
  assign two        = cfg.delimiter_length[1];
  assign dlen       = two ? CW'(2) : CW'(1);

  // scan: eval_idx is the offset of the byte now on mem_rdata
  assign scan_issue = (state == rbdf_pkg::FSM_SCAN) && (idx < fill);
  assign m1 = !two && (mem_rdata == cfg.delimiter_first);
  assign m2 = two && (eval_idx != '0) && (prev_byte == cfg.delimiter_first)
              && (mem_rdata == cfg.delimiter_second);
  assign found     = (state == rbdf_pkg::FSM_SCAN) && eval_valid && (m1 || m2);
  assign at        = m1 ? eval_idx : eval_idx - CW'(1);
  assign scan_miss = (state == rbdf_pkg::FSM_SCAN) && eval_valid && !(m1 || m2)
                     && (eval_idx + CW'(1) == fill);

  assign emit_load  = (state == rbdf_pkg::FSM_EMIT) && pend && out_free;
  assign emit_last  = (ld + CW'(1) == msg_len);
  assign emit_issue = (state == rbdf_pkg::FSM_EMIT) && (idx < msg_len) && (!pend || emit_load);

  always_comb begin
    state_next = state;
    unique case (state)
      rbdf_pkg::FSM_IDLE: begin
        if (accept) begin
          if (req.operation == rbdf_pkg::OP_READ_MSG && fill >= dlen) begin
            state_next = rbdf_pkg::FSM_SCAN;
          end else if (req.operation == rbdf_pkg::OP_READ_ALL && fill != '0) begin
            state_next = rbdf_pkg::FSM_EMIT;
          end
        end
      end
      rbdf_pkg::FSM_SCAN: begin
        if (found) begin
          state_next = (at == '0) ? rbdf_pkg::FSM_RESP : rbdf_pkg::FSM_EMIT;
        end else if (scan_miss) begin
          state_next = rbdf_pkg::FSM_RESP;
        end
      end
      rbdf_pkg::FSM_EMIT: begin
        if (emit_load && emit_last) begin
          state_next = rbdf_pkg::FSM_IDLE;
        end
      end
      rbdf_pkg::FSM_RESP: begin
        if (out_free) begin
          state_next = rbdf_pkg::FSM_IDLE;
        end
      end
      default: state_next = rbdf_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    rp_next          = rp;
    wp_next          = wp;
    fill_next        = fill;
    base_next        = base;
    idx_next         = idx;
    eval_valid_next  = 1'b0;
    eval_idx_next    = eval_idx;
    prev_byte_next   = prev_byte;
    pend_next        = pend;
    ld_next          = ld;
    msg_len_next     = msg_len;
    resp_status_next = resp_status;
    out_valid_next   = out_valid && rsp_stall;
    out_item_next    = out_item;
    mem_we           = 1'b0;
    mem_waddr        = wp;
    mem_wdata        = req.data_byte;
    mem_re           = 1'b0;
    mem_raddr        = add_wrap(rp, idx);

    unique case (state)
      rbdf_pkg::FSM_IDLE: begin
        if (accept) begin
          out_item_next.out_byte   = '0;
          out_item_next.last       = 1'b1;
          out_item_next.msg_length = '0;
          idx_next = '0;
          ld_next  = '0;
          pend_next = 1'b0;
          unique case (req.operation)
            rbdf_pkg::OP_WRITE: begin
              out_valid_next = 1'b1;
              if (fill == CW'(DEPTH)) begin
                out_item_next.status = rbdf_pkg::ST_FULL;
              end else begin
                out_item_next.status = rbdf_pkg::ST_WRITTEN;
                mem_we    = 1'b1;
                wp_next   = add_wrap(wp, CW'(1));
                fill_next = fill + CW'(1);
              end
            end
            rbdf_pkg::OP_READ_MSG: begin
              if (fill < dlen) begin
                out_valid_next       = 1'b1;
                out_item_next.status = rbdf_pkg::ST_NO_MSG;
              end
            end
            rbdf_pkg::OP_READ_ALL: begin
              if (fill == '0) begin
                out_valid_next       = 1'b1;
                out_item_next.status = rbdf_pkg::ST_EMPTY;
              end else begin
                msg_len_next = fill;
                base_next    = rp;
              end
              rp_next   = '0;
              wp_next   = '0;
              fill_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      rbdf_pkg::FSM_SCAN: begin
        if (scan_issue) begin
          mem_re          = 1'b1;
          idx_next        = idx + CW'(1);
          eval_valid_next = 1'b1;
          eval_idx_next   = idx;
        end
        if (eval_valid) begin
          prev_byte_next = mem_rdata;
        end
        if (found) begin
          eval_valid_next  = 1'b0;
          msg_len_next     = at;
          base_next        = rp;
          idx_next         = '0;
          resp_status_next = rbdf_pkg::ST_EMPTY;
          rp_next          = add_wrap(rp, at + dlen);
          fill_next        = fill - (at + dlen);
        end else if (scan_miss) begin
          resp_status_next = rbdf_pkg::ST_NO_MSG;
        end
      end
      rbdf_pkg::FSM_EMIT: begin
        mem_raddr = add_wrap(base, idx);
        if (emit_issue) begin
          mem_re   = 1'b1;
          idx_next = idx + CW'(1);
        end
        if (emit_load) begin
          out_valid_next           = 1'b1;
          out_item_next.out_byte   = mem_rdata;
          out_item_next.last       = emit_last;
          out_item_next.msg_length = rbdf_pkg::LEN_W'(msg_len);
          out_item_next.status     = rbdf_pkg::ST_DATA;
          ld_next = ld + CW'(1);
        end
        pend_next = emit_issue || (pend && !emit_load);
      end
      rbdf_pkg::FSM_RESP: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_item_next.out_byte   = '0;
          out_item_next.last       = 1'b1;
          out_item_next.msg_length = '0;
          out_item_next.status     = resp_status;
        end
      end
      default: begin
      end
    endcase

    // start position write empties the store
    if (rs.restart) begin
      rp_next   = wrap_start(rs.start_position);
      wp_next   = wrap_start(rs.start_position);
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rbdf_pkg::FSM_IDLE;
      rp         <= '0;
      wp         <= '0;
      fill       <= '0;
      eval_valid <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rp         <= rp_next;
      wp         <= wp_next;
      fill       <= fill_next;
      eval_valid <= eval_valid_next;
      pend       <= pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    base        <= base_next;
    idx         <= idx_next;
    eval_idx    <= eval_idx_next;
    prev_byte   <= prev_byte_next;
    ld          <= ld_next;
    msg_len     <= msg_len_next;
    resp_status <= resp_status_next;
    out_item    <= out_item_next;
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_item;

endmodule

[rtl/core/ring_buffer_delimiter_framer_core.sv]
// ---------------------------------------------------------------------------
// ring_buffer_delimiter_framer_core
// Circular byte store that splits its contents into delimited messages.
// ---------------------------------------------------------------------------
// A write word stores one byte and answers in one result; writes are taken
// one per cycle as long as the result side keeps up. A read-message word
// first scans the store from the read pointer, one byte per cycle through
// the single read port, then reads the message out again at one byte per
// cycle while the result side keeps up; the request side is stalled for
// the whole read. A read-all word emits every stored byte at one per cycle
// as long as the result side keeps up. Single-result answers (no message,
// empty message) come after the scan, or at once when fewer bytes than the
// delimiter are stored or a read-all finds the store empty. The store needs
// no clearing pass after reset.
module ring_buffer_delimiter_framer_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rbdf_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rbdf_pkg::out_item_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int unsigned PW = $clog2(DEPTH);

  rbdf_pkg::delim_cfg_t        cfg;
  rbdf_pkg::restart_t          rs;
  logic                        cfg_wr;
  logic                        mem_we, mem_re;
  logic [PW-1:0]               mem_waddr, mem_raddr;
  logic [rbdf_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_length <= rbdf_pkg::RST_DELIM_LEN;
      cfg.delimiter_first  <= rbdf_pkg::RST_DELIM_FIRST;
      cfg.delimiter_second <= rbdf_pkg::RST_DELIM_SECOND;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rbdf_pkg::CFG_DELIM_LEN:    cfg.delimiter_length <= cfg_data[1:0];
        rbdf_pkg::CFG_DELIM_FIRST:  cfg.delimiter_first  <= cfg_data;
        rbdf_pkg::CFG_DELIM_SECOND: cfg.delimiter_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign rs.restart        = cfg_wr && (cfg_index == rbdf_pkg::CFG_START_POS);
  assign rs.start_position = cfg_data[rbdf_pkg::START_W-1:0];

  rbdf_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg       (cfg),
    .rs        (rs),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rbdf_mem #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/core/rbdf_checker.sv]
// ---------------------------------------------------------------------------
// rbdf_checker
// Port-level checks of the framer, bound to the top level.
// ---------------------------------------------------------------------------
`include "ring_buffer_delimiter_framer_core_macros.svh"

module rbdf_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input rbdf_pkg::out_item_t rsp
);

  `RBDF_ASSERT_ALWAYS(a_rst_clears_rsp, clk, rst |=> !rsp_valid, "result valid after reset")

  `RBDF_ASSERT(a_rsp_hold, clk, rst,
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")

  // no new word while a result is stuck
  `RBDF_ASSERT(a_no_accept_blocked, clk, rst,
    req_valid && rsp_valid && rsp_stall |-> req_stall, "word taken while result blocked")

  `RBDF_ASSERT(a_status_fields, clk, rst,
    rsp_valid && rsp.status != rbdf_pkg::ST_DATA |->
      rsp.last && rsp.out_byte == '0 && rsp.msg_length == '0,
    "status result carries data")

  `RBDF_ASSERT(a_data_len, clk, rst,
    rsp_valid && rsp.status == rbdf_pkg::ST_DATA |->
      rsp.msg_length != '0 && rsp.msg_length <= rbdf_pkg::LEN_W'(DEPTH),
    "bad message length")

endmodule

bind ring_buffer_delimiter_framer_core rbdf_checker #(
  .DEPTH (DEPTH)
) u_rbdf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimiter framing ring buffer. A queue-fed
// driver sends write, read-message and read-all words, while a monitor runs
// a behavioral copy of the store and compares every result word. Several
// delimiter settings and start positions are run. Random stalls are applied
// on both sides.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned   DEPTH       = 64;
  localparam rbdf_pkg::op_t OP_RESERVED = rbdf_pkg::op_t'(2'd3);
  localparam int            SETTLE      = 200;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  rbdf_pkg::in_item_t  req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rbdf_pkg::out_item_t rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [7:0]          cfg_data = '0;

  ring_buffer_delimiter_framer_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the buffer and its settings
  logic [7:0] buf_store [DEPTH];
  logic [5:0] buf_rd, buf_wr;
  logic [6:0] buf_fill;
  logic [1:0] set_dlen;
  logic [7:0] set_first, set_second;

  rbdf_pkg::in_item_t  word_q [$];
  rbdf_pkg::out_item_t rsp_owed_q [$];
  bit        req_fire = 1'b0;
  bit        steady = 1'b0;
  int        n_gen = 0, n_in = 0, n_out = 0, n_msgs = 0, n_full = 0, n_fail = 0;

  function automatic rbdf_pkg::out_item_t rsp_word(logic [7:0] b, logic l, logic [6:0] len,
                                                   rbdf_pkg::status_t st);
    rbdf_pkg::out_item_t r;
    r.out_byte   = b;
    r.last       = l;
    r.msg_length = len;
    r.status     = st;
    return r;
  endfunction

  task automatic buffer_take_word(rbdf_pkg::in_item_t w);
    int  dlen, at, n, k;
    bit  found;
    case (w.operation)
      rbdf_pkg::OP_WRITE: begin
        if (buf_fill >= DEPTH) begin
          rsp_owed_q.push_back(rsp_word(8'd0, 1'b1, 7'd0, rbdf_pkg::ST_FULL));
          n_full++;
        end else begin
          buf_store[buf_wr] = w.data_byte;
          buf_wr = 6'((buf_wr + 1) % DEPTH);
          buf_fill++;
          rsp_owed_q.push_back(rsp_word(8'd0, 1'b1, 7'd0, rbdf_pkg::ST_WRITTEN));
        end
      end
      rbdf_pkg::OP_READ_MSG: begin
        dlen  = (set_dlen >= 2) ? 2 : 1;
        found = 1'b0;
        at    = 0;
        for (k = 0; k + dlen <= buf_fill && !found; k++) begin
          if (buf_store[6'((buf_rd + k) % DEPTH)] == set_first &&
              (dlen == 1 || buf_store[6'((buf_rd + k + 1) % DEPTH)] == set_second)) begin
            found = 1'b1;
            at    = k;
          end
        end
        if (!found) begin
          rsp_owed_q.push_back(rsp_word(8'd0, 1'b1, 7'd0, rbdf_pkg::ST_NO_MSG));
        end else begin
          if (at == 0)
            rsp_owed_q.push_back(rsp_word(8'd0, 1'b1, 7'd0, rbdf_pkg::ST_EMPTY));
          for (k = 0; k < at; k++)
            rsp_owed_q.push_back(rsp_word(buf_store[6'((buf_rd + k) % DEPTH)],
                                          k + 1 == at, 7'(at), rbdf_pkg::ST_DATA));
          buf_rd   = 6'((buf_rd + at + dlen) % DEPTH);
          buf_fill = 7'(buf_fill - at - dlen);
          n_msgs++;
        end
      end
      rbdf_pkg::OP_READ_ALL: begin
        n = int'(buf_fill);
        if (n == 0)
          rsp_owed_q.push_back(rsp_word(8'd0, 1'b1, 7'd0, rbdf_pkg::ST_EMPTY));
        for (k = 0; k < n; k++)
          rsp_owed_q.push_back(rsp_word(buf_store[6'((buf_rd + k) % DEPTH)],
                                        k + 1 == n, 7'(n), rbdf_pkg::ST_DATA));
        buf_fill = '0;
        buf_rd   = '0;
        buf_wr   = '0;
      end
      default: ;  // unused code: no result, no state change
    endcase
  endtask

  // Request driver: holds a stalled word, otherwise idles at random
  always @(negedge clk) begin : drive_req
    bit hold, idle;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_fire)
        word_q.delete(0);
      hold = req_valid && !req_fire;
      idle = !steady && ($urandom_range(0, 99) < 29);
      if (!hold) begin
        if (word_q.size() != 0 && !idle) begin
          req_valid <= 1'b1;
          req       <= word_q[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    rsp_stall <= !rst && !steady && ($urandom_range(0, 99) < 29);
  end

  // Monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk) begin : watch
    rbdf_pkg::out_item_t want;
    if (rst) begin
      req_fire = 1'b0;
    end else begin
      req_fire = req_valid && !req_stall;
      if (req_fire) begin
        n_in++;
        buffer_take_word(req);
      end
      if (rsp_valid && !rsp_stall) begin
        n_out++;
        if (rsp_owed_q.size() == 0) begin
          $error("result word with none pending: byte %0h last %0b len %0d status %0d",
                 rsp.out_byte, rsp.last, rsp.msg_length, rsp.status);
          n_fail++;
        end else begin
          want = rsp_owed_q.pop_front();
          if (rsp.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, rsp.out_byte);
            n_fail++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp.last);
            n_fail++;
          end
          if (rsp.msg_length !== want.msg_length) begin
            $error("msg_length: expected %0d, got %0d", want.msg_length, rsp.msg_length);
            n_fail++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            n_fail++;
          end
        end
      end
    end
  end

  task automatic cfg_write(rbdf_pkg::cfg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rbdf_pkg::CFG_DELIM_LEN:    set_dlen   = val[1:0];
      rbdf_pkg::CFG_DELIM_FIRST:  set_first  = val;
      rbdf_pkg::CFG_DELIM_SECOND: set_second = val;
      rbdf_pkg::CFG_START_POS: begin
        buf_rd   = 6'(val[5:0] % DEPTH);
        buf_wr   = buf_rd;
        buf_fill = '0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_word(rbdf_pkg::op_t op, logic [7:0] d);
    rbdf_pkg::in_item_t w;
    w.operation = op;
    w.data_byte = d;
    word_q.push_back(w);
    if (op != OP_RESERVED)
      n_gen++;
  endtask

  // Random content that hits the delimiter bytes now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return set_first;
      1:       return set_second;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic gen_traffic(int target, bit fill_burst);
    int stop, kind, n;
    stop = n_gen + target;
    // overfill across the wrap point, then drain everything
    if (fill_burst) begin
      repeat (DEPTH + 3) push_word(rbdf_pkg::OP_WRITE, 8'($urandom_range(0, 255)));
      push_word(rbdf_pkg::OP_READ_MSG, 8'($urandom_range(0, 255)));
      push_word(rbdf_pkg::OP_READ_ALL, 8'($urandom_range(0, 255)));
    end
    while (n_gen < stop) begin
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (kind < 60) begin
        repeat (n) push_word(rbdf_pkg::OP_WRITE, pick_byte());
        push_word(rbdf_pkg::OP_WRITE, set_first);
        if (set_dlen >= 2)
          push_word(rbdf_pkg::OP_WRITE, set_second);
        if ($urandom_range(0, 3) != 0)
          push_word(rbdf_pkg::OP_READ_MSG, 8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
        // partial delimiter: only one of the two bytes
        repeat (n) push_word(rbdf_pkg::OP_WRITE, pick_byte());
        push_word(rbdf_pkg::OP_WRITE, $urandom_range(0, 1) ? set_first : set_second);
        push_word(rbdf_pkg::OP_READ_MSG, 8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        push_word(rbdf_pkg::OP_READ_ALL, 8'($urandom_range(0, 255)));
      end else begin
        push_word(rbdf_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait for all words accepted and answered, then let trailing work settle
  task automatic drain();
    while (word_q.size() != 0 || rsp_owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    foreach (buf_store[i]) buf_store[i] = '0;
    buf_rd     = '0;
    buf_wr     = '0;
    buf_fill   = '0;
    set_dlen   = rbdf_pkg::RST_DELIM_LEN;
    set_first  = rbdf_pkg::RST_DELIM_FIRST;
    set_second = rbdf_pkg::RST_DELIM_SECOND;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings (CR LF)
    push_word(rbdf_pkg::OP_READ_MSG, 8'hFF);
    push_word(rbdf_pkg::OP_READ_ALL, 8'h00);
    push_word(OP_RESERVED, 8'hA5);
    push_word(rbdf_pkg::OP_WRITE, 8'h00);
    push_word(rbdf_pkg::OP_WRITE, 8'hFF);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_FIRST);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_SECOND);
    push_word(rbdf_pkg::OP_READ_MSG, 8'h5A);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_FIRST);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_SECOND);
    push_word(rbdf_pkg::OP_READ_MSG, 8'h00);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_FIRST);
    push_word(rbdf_pkg::OP_READ_MSG, 8'h00);
    push_word(rbdf_pkg::OP_WRITE, rbdf_pkg::RST_DELIM_SECOND);
    push_word(rbdf_pkg::OP_READ_MSG, 8'hFF);
    push_word(rbdf_pkg::OP_WRITE, 8'h55);
    push_word(rbdf_pkg::OP_WRITE, 8'hAA);
    push_word(rbdf_pkg::OP_READ_ALL, 8'hFF);
    push_word(rbdf_pkg::OP_READ_MSG, 8'h00);
    drain();

    cfg_write(rbdf_pkg::CFG_DELIM_LEN, 8'd1);
    cfg_write(rbdf_pkg::CFG_DELIM_FIRST, 8'h00);
    cfg_write(rbdf_pkg::CFG_DELIM_SECOND, 8'hFF);
    cfg_write(rbdf_pkg::CFG_START_POS, 8'd63);
    gen_traffic(40, 1'b1);
    drain();

    // no idling on either side here
    steady = 1'b1;
    cfg_write(rbdf_pkg::CFG_DELIM_LEN, 8'd0);
    cfg_write(rbdf_pkg::CFG_DELIM_FIRST, 8'hFF);
    cfg_write(rbdf_pkg::CFG_DELIM_SECOND, 8'h00);
    cfg_write(rbdf_pkg::CFG_START_POS, 8'd0);
    gen_traffic(45, 1'b0);
    drain();
    steady = 1'b0;

    cfg_write(rbdf_pkg::CFG_DELIM_LEN, 8'd3);
    cfg_write(rbdf_pkg::CFG_DELIM_FIRST, 8'h00);
    cfg_write(rbdf_pkg::CFG_DELIM_SECOND, 8'hFF);
    cfg_write(rbdf_pkg::CFG_START_POS, 8'd32);
    gen_traffic(45, 1'b0);
    drain();

    cfg_write(rbdf_pkg::CFG_DELIM_LEN, 8'd2);
    cfg_write(rbdf_pkg::CFG_DELIM_FIRST, 8'($urandom_range(0, 255)));
    cfg_write(rbdf_pkg::CFG_DELIM_SECOND, 8'($urandom_range(0, 255)));
    cfg_write(rbdf_pkg::CFG_START_POS, 8'($urandom_range(0, 63)));
    gen_traffic(55, 1'b0);
    drain();

    $display("Sent %0d request words over five delimiter settings; checked %0d result words.",
             n_in, n_out);
    $display("Framed %0d messages, saw %0d writes dropped on a full store.", n_msgs, n_full);
    if (n_fail == 0 && rsp_owed_q.size() == 0) begin
      $display("ring_buffer_delimiter_framer_core regression: pass");
    end else begin
      $display("ring_buffer_delimiter_framer_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d result words outstanding.", rsp_owed_q.size());
    $display("ring_buffer_delimiter_framer_core regression: fail");
    $finish;
  end

endmodule
